### rtl/core/kdsm_pkg.sv
// Package for the keypad digit substring matcher.
// Holds widths, register indexes and the keypad class function.
// No dependencies; used by the interfaces and all modules.
package kdsm_pkg;

    // Field and register widths
    localparam int CHAR_W        = 8;
    localparam int DIGITS_W      = 64;
    localparam int LENGTH_W      = 5;
    localparam int TOTAL_W       = 16;
    localparam int CFG_INDEX_W   = 2;
    localparam int CFG_DATA_W    = 64;
    localparam int DIGIT_W       = 4;
    localparam int NUM_KEYS      = 10;
    localparam int MAX_PATTERN_DEFAULT = 16;

    // Configuration register indexes
    typedef enum logic [CFG_INDEX_W-1:0] {
        REG_PATTERN_DIGITS = 2'd0,
        REG_PATTERN_LENGTH = 2'd1
    } cfg_reg_t;

    // Key digit for each letter a..z
    localparam logic [DIGIT_W-1:0] LETTER_KEY [26] = '{
        4'd2, 4'd2, 4'd2, 4'd3, 4'd3, 4'd3, 4'd4, 4'd4, 4'd4,
        4'd5, 4'd5, 4'd5, 4'd6, 4'd6, 4'd6, 4'd7, 4'd7, 4'd7, 4'd7,
        4'd8, 4'd8, 4'd8, 4'd9, 4'd9, 4'd9, 4'd9
    };

    // Bit d set: the character falls in keypad class d
    function automatic logic [NUM_KEYS-1:0] key_classes(input logic [CHAR_W-1:0] c);
        logic [NUM_KEYS-1:0] cls;
        logic [CHAR_W-1:0]   ofs;
        cls = '0;
        ofs = '0;
        if (c >= 8'h30 && c <= 8'h39)
        begin
            ofs = c - 8'h30;
            cls[ofs[3:0]] = 1'b1;
        end
        else if (c == 8'h2B)
        begin
            cls[0] = 1'b1;
        end
        else if (c >= 8'h61 && c <= 8'h7A)
        begin
            ofs = c - 8'h61;
            cls[LETTER_KEY[ofs[4:0]]] = 1'b1;
        end
        else if (c >= 8'h41 && c <= 8'h5A)
        begin
            ofs = c - 8'h41;
            cls[LETTER_KEY[ofs[4:0]]] = 1'b1;
        end
        return cls;
    endfunction

endpackage

### rtl/core/kdsm_if.sv
// Handshake channels of the keypad digit substring matcher.
// Character stream, result stream and configuration write channel.
// Depends on kdsm_pkg.
interface kdsm_char_if;
    logic                          valid;
    logic                          ready;
    logic [kdsm_pkg::CHAR_W-1:0]   char_code;
    logic                          is_terminator;
    logic                          ends_record;

    modport source (output valid, char_code, is_terminator, ends_record, input ready);
    modport sink   (input valid, char_code, is_terminator, ends_record, output ready);
endinterface

interface kdsm_result_if;
    logic                          valid;
    logic                          ready;
    logic                          record_matched;
    logic [kdsm_pkg::TOTAL_W-1:0]  matched_total;

    modport source (output valid, record_matched, matched_total, input ready);
    modport sink   (input valid, record_matched, matched_total, output ready);
endinterface

interface kdsm_cfg_if;
    logic                              valid;
    logic                              ready;
    logic [kdsm_pkg::CFG_INDEX_W-1:0]  index;
    logic [kdsm_pkg::CFG_DATA_W-1:0]   data;

    modport source (output valid, index, data, input ready);
    modport sink   (input valid, index, data, output ready);
endinterface

### rtl/core/kdsm_match_unit.sv
// Per-position compare of one character against the pattern digits.
// Bit k of eq is set when the character falls in the class of digit k.
// Depends on kdsm_pkg.
module kdsm_match_unit #(
    parameter int MAX_PATTERN = kdsm_pkg::MAX_PATTERN_DEFAULT
) (
    input  logic [kdsm_pkg::CHAR_W-1:0]   char_code,
    input  logic [kdsm_pkg::DIGITS_W-1:0] pattern_digits,
    output logic [MAX_PATTERN-1:0]        eq
);

    logic [kdsm_pkg::NUM_KEYS-1:0] cls;

    assign cls = kdsm_pkg::key_classes(char_code);

    // One class lookup per pattern position; digits above nine never match
    always_comb
    begin
        logic [kdsm_pkg::DIGIT_W-1:0] d;
        d  = '0;
        eq = '0;
        for (int k = 0; k < MAX_PATTERN; k++)
        begin
            d = pattern_digits[k*kdsm_pkg::DIGIT_W +: kdsm_pkg::DIGIT_W];
            if (d <= 4'd9)
            begin
                eq[k] = cls[d];
            end
        end
    end

endmodule

### rtl/core/keypad_digit_substring_matcher.sv
// Keypad digit substring matcher: takes one character item per cycle, back to
// back, unless a record-end item waits in the input register for a busy result
// register. Items enter an input register; a shift-and update and a result
// register follow. A result appears only for a terminator item with ends_record
// set; while a result waits, the input keeps flowing up to the next record end.
// The user must load the pattern through the configuration channel while the
// block is idle; the block does not enforce this. No clearing pass after reset.
// Depends on kdsm_pkg, kdsm_if and kdsm_match_unit.
module keypad_digit_substring_matcher #(
    parameter int MAX_PATTERN = kdsm_pkg::MAX_PATTERN_DEFAULT
) (
    input  logic          clk,
    input  logic          rst_n,
    kdsm_cfg_if.sink      cfg,
    kdsm_char_if.sink     char_stream,
    kdsm_result_if.source result_stream
);

    // Configuration registers
    logic [kdsm_pkg::DIGITS_W-1:0] digits_reg;
    logic [kdsm_pkg::LENGTH_W-1:0] length_reg;

    // Input register stage
    logic                        s1_valid_reg;
    logic [kdsm_pkg::CHAR_W-1:0] s1_char_reg;
    logic                        s1_term_reg;
    logic                        s1_ends_reg;

    // Match state
    logic [MAX_PATTERN-1:0]       partial_reg, partial_next;
    logic                         found_reg, found_next;
    logic [kdsm_pkg::TOTAL_W-1:0] count_reg, count_next;

    // Result register
    logic                         out_valid_reg, out_valid_next;
    logic                         out_matched_reg;
    logic [kdsm_pkg::TOTAL_W-1:0] out_total_reg;

    logic                   out_free;
    logic                   s1_rec_end;
    logic                   s1_adv;
    logic                   in_take;
    logic [MAX_PATTERN-1:0] eq;
    logic [MAX_PATTERN-1:0] shifted;
    logic                   hit;

    // Handshake control
    assign out_free          = !out_valid_reg || result_stream.ready;
    assign s1_rec_end        = s1_term_reg && s1_ends_reg;
    assign s1_adv            = s1_valid_reg && (!s1_rec_end || out_free);
    assign char_stream.ready = !s1_valid_reg || s1_adv;
    assign in_take           = char_stream.valid && char_stream.ready;
    assign cfg.ready         = 1'b1;

    // Configuration writes
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            digits_reg <= '0;
            length_reg <= '0;
        end
        else if (cfg.valid)
        begin
            unique case (cfg.index)
                kdsm_pkg::REG_PATTERN_DIGITS: digits_reg <= cfg.data;
                kdsm_pkg::REG_PATTERN_LENGTH: length_reg <= cfg.data[kdsm_pkg::LENGTH_W-1:0];
                default: ;
            endcase
        end
    end

    // Input register
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            s1_valid_reg <= 1'b0;
        end
        else if (char_stream.ready)
        begin
            s1_valid_reg <= char_stream.valid;
        end
    end

    always_ff @(posedge clk)
    begin
        if (in_take)
        begin
            s1_char_reg <= char_stream.char_code;
            s1_term_reg <= char_stream.is_terminator;
            s1_ends_reg <= char_stream.ends_record;
        end
    end

    kdsm_match_unit #(
        .MAX_PATTERN (MAX_PATTERN)
    ) u_match (
        .char_code      (s1_char_reg),
        .pattern_digits (digits_reg),
        .eq             (eq)
    );

    // Shift-and update and pattern-length tap
    always_comb
    begin
        shifted = MAX_PATTERN'({partial_reg, 1'b1});
        hit     = 1'b0;
        for (int k = 0; k < MAX_PATTERN; k++)
        begin
            if (length_reg == kdsm_pkg::LENGTH_W'(k + 1))
            begin
                hit = shifted[k] & eq[k];
            end
        end
    end

    // Next match state
    always_comb
    begin
        partial_next = partial_reg;
        found_next   = found_reg;
        count_next   = count_reg;
        if (s1_adv)
        begin
            if (!s1_term_reg)
            begin
                partial_next = shifted & eq;
                found_next   = found_reg | hit;
            end
            else
            begin
                partial_next = '0;
                if (s1_ends_reg)
                begin
                    found_next = 1'b0;
                    if (found_reg && count_reg != {kdsm_pkg::TOTAL_W{1'b1}})
                    begin
                        count_next = count_reg + 1'b1;
                    end
                end
            end
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            partial_reg <= '0;
            found_reg   <= 1'b0;
            count_reg   <= '0;
        end
        else
        begin
            partial_reg <= partial_next;
            found_reg   <= found_next;
            count_reg   <= count_next;
        end
    end

    // Result register
    always_comb
    begin
        out_valid_next = out_valid_reg && !result_stream.ready;
        if (s1_adv && s1_rec_end)
        begin
            out_valid_next = 1'b1;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            out_valid_reg <= 1'b0;
        end
        else
        begin
            out_valid_reg <= out_valid_next;
        end
    end

    always_ff @(posedge clk)
    begin
        if (s1_adv && s1_rec_end)
        begin
            out_matched_reg <= found_reg;
            out_total_reg   <= count_next;
        end
    end

    assign result_stream.valid          = out_valid_reg;
    assign result_stream.record_matched = out_matched_reg;
    assign result_stream.matched_total  = out_total_reg;

    // Checks
    a_term_clears: assert property (@(posedge clk) disable iff (!rst_n)
        s1_adv && s1_term_reg |=> partial_reg == '0)
        else $error("partial state not cleared at field end");

    a_rec_end_clears: assert property (@(posedge clk) disable iff (!rst_n)
        s1_adv && s1_rec_end |=> !found_reg && out_valid_reg)
        else $error("record end did not clear found flag or post result");

    a_count_monotonic: assert property (@(posedge clk) disable iff (!rst_n)
        1'b1 |=> count_reg >= $past(count_reg))
        else $error("match count decreased");

    a_zero_len_no_hit: assert property (@(posedge clk) disable iff (!rst_n)
        length_reg == '0 && !found_reg && !(s1_adv && s1_rec_end) |=> !found_reg)
        else $error("zero-length pattern produced a match");

endmodule

### dv/keypad_digit_substring_matcher_test.sv
`timescale 1ns / 100ps
// Self-checking bench for keypad_digit_substring_matcher: drives contact records,
// predicts each record verdict and the running match tally, checks every result.
// Depends on kdsm_pkg, the kdsm interfaces and the matcher RTL.
module keypad_digit_substring_matcher_test;

    localparam int CHAR_W     = kdsm_pkg::CHAR_W;
    localparam int DIGITS_W   = kdsm_pkg::DIGITS_W;
    localparam int LENGTH_W   = kdsm_pkg::LENGTH_W;
    localparam int TOTAL_W    = kdsm_pkg::TOTAL_W;
    localparam int CFG_DATA_W = kdsm_pkg::CFG_DATA_W;
    localparam int DIGIT_W    = kdsm_pkg::DIGIT_W;
    localparam int NUM_KEYS   = kdsm_pkg::NUM_KEYS;

    localparam int CYCLE_LIMIT    = 2_000_000;
    localparam int SETTLE_CYCLES  = 8;
    localparam int HOLDOFF_CYCLES = 300;
    localparam int RANDOM_ITEMS   = 500;
    localparam int RANDOM_PHASES  = 10;
    localparam int REPORT_LIMIT   = 10;
    localparam int PATTERN_SLOTS  = kdsm_pkg::MAX_PATTERN_DEFAULT;

    // Receiver stall patterns
    typedef enum int {
        RX_STEADY,
        RX_COIN,
        RX_SPARSE,
        RX_MOSTLY
    } rx_pattern_t;

    typedef struct packed {
        logic               matched;
        logic [TOTAL_W-1:0] total;
    } record_verdict_t;

    logic clk;
    logic rst_n;

    kdsm_cfg_if    cfg_bus ();
    kdsm_char_if   char_bus ();
    kdsm_result_if result_bus ();

    keypad_digit_substring_matcher dut (
        .clk           (clk),
        .rst_n         (rst_n),
        .cfg           (cfg_bus),
        .char_stream   (char_bus),
        .result_stream (result_bus)
    );

    // Matcher state as the bench sees it
    logic [DIGITS_W-1:0]      pat_digits;
    logic [LENGTH_W-1:0]      pat_len;
    logic [PATTERN_SLOTS-1:0] run_bits;
    logic                     found_in_record;
    logic [TOTAL_W-1:0]       match_tally;
    record_verdict_t          record_verdicts_due[$];

    // Stimulus and bookkeeping
    int  items_sent;
    int  burst_left;
    bit  gaps_on;
    bit  holdoff_request;
    bit  hold_active;
    int  mismatches;
    int  records_checked;
    int  records_matched;
    int  cycle_count;

    // Clock
    initial
    begin
        clk = 1'b0;
        forever #5 clk = ~clk;
    end

    // Run limit
    initial
    begin
        cycle_count = 0;
        forever
        begin
            @(posedge clk);
            cycle_count++;
            if (cycle_count >= CYCLE_LIMIT)
            begin
                $display("Timeout after %0d cycles", cycle_count);
                $display("Some tests failed");
                $finish;
            end
        end
    end

    // Keypad classes of one character: bit d set when it stands for digit d
    function automatic logic [NUM_KEYS-1:0] keypad_classes(logic [CHAR_W-1:0] c);
        logic [NUM_KEYS-1:0] cls;
        logic [CHAR_W-1:0]   lc;
        cls = '0;
        lc  = c | 8'h20;
        if (c >= "0" && c <= "9")
            cls[c - "0"] = 1'b1;
        else if (c == "+")
            cls[0] = 1'b1;
        else if (lc >= "a" && lc <= "z")
        begin
            if (lc <= "c")      cls[2] = 1'b1;
            else if (lc <= "f") cls[3] = 1'b1;
            else if (lc <= "i") cls[4] = 1'b1;
            else if (lc <= "l") cls[5] = 1'b1;
            else if (lc <= "o") cls[6] = 1'b1;
            else if (lc <= "s") cls[7] = 1'b1;
            else if (lc <= "v") cls[8] = 1'b1;
            else                cls[9] = 1'b1;
        end
        return cls;
    endfunction

    // Advance the shift-and state by one item; queue a verdict on record end
    function automatic void track_keypad_item(logic [CHAR_W-1:0] c, logic term, logic ends);
        logic [NUM_KEYS-1:0]      cls;
        logic [PATTERN_SLOTS-1:0] hit;
        logic [DIGIT_W-1:0]       d;
        record_verdict_t          v;
        if (!term)
        begin
            cls = keypad_classes(c);
            hit = '0;
            for (int k = 0; k < PATTERN_SLOTS; k++)
            begin
                d = pat_digits[DIGIT_W*k +: DIGIT_W];
                if (d <= 4'd9 && cls[d])
                    hit[k] = 1'b1;
            end
            run_bits = ((run_bits << 1) | 1'b1) & hit;
            if (pat_len >= 1 && pat_len <= PATTERN_SLOTS && run_bits[pat_len - 1])
                found_in_record = 1'b1;
            return;
        end
        run_bits = '0;
        if (!ends)
            return;
        if (found_in_record && match_tally != 16'hFFFF)
            match_tally++;
        v.matched = found_in_record;
        v.total   = match_tally;
        record_verdicts_due.push_back(v);
        found_in_record = 1'b0;
    endfunction

    // One character item; with gaps on, the sender works in bursts with random gaps
    task automatic send_item(logic [CHAR_W-1:0] c, logic term, logic ends);
        int gap;
        if (gaps_on && burst_left == 0)
        begin
            burst_left = $urandom_range(1, 24);
            gap = $urandom_range(1, 6);
            @(negedge clk);
            char_bus.valid <= 1'b0;
            repeat (gap - 1) @(negedge clk);
        end
        if (burst_left > 0)
            burst_left--;
        @(negedge clk);
        char_bus.valid         <= 1'b1;
        char_bus.char_code     <= c;
        char_bus.is_terminator <= term;
        char_bus.ends_record   <= ends;
        @(posedge clk);
        while (!char_bus.ready)
            @(posedge clk);
        items_sent++;
        track_keypad_item(c, term, ends);
    endtask

    // Stop offering items and let every pending verdict come back
    task automatic drain_results;
        @(negedge clk);
        char_bus.valid <= 1'b0;
        while (record_verdicts_due.size() != 0)
            @(posedge clk);
    endtask

    // Idle point for register writes: all results drained, then the pipeline settles
    task automatic wait_block_idle;
        drain_results();
        repeat (SETTLE_CYCLES) @(posedge clk);
    endtask

    task automatic write_reg(kdsm_pkg::cfg_reg_t idx, logic [CFG_DATA_W-1:0] value);
        @(negedge clk);
        cfg_bus.valid <= 1'b1;
        cfg_bus.index <= idx;
        cfg_bus.data  <= value;
        @(posedge clk);
        while (!cfg_bus.ready)
            @(posedge clk);
        if (idx == kdsm_pkg::REG_PATTERN_DIGITS)
            pat_digits = value;
        else if (idx == kdsm_pkg::REG_PATTERN_LENGTH)
            pat_len = value[LENGTH_W-1:0];
        @(negedge clk);
        cfg_bus.valid <= 1'b0;
    endtask

    task automatic set_pattern(logic [DIGITS_W-1:0] digits, logic [LENGTH_W-1:0] len);
        wait_block_idle();
        write_reg(kdsm_pkg::REG_PATTERN_DIGITS, digits);
        write_reg(kdsm_pkg::REG_PATTERN_LENGTH, {{(CFG_DATA_W-LENGTH_W){1'b0}}, len});
    endtask

    // A character that stands for keypad digit d (anything for digits above 9)
    function automatic logic [CHAR_W-1:0] keypad_glyph(logic [DIGIT_W-1:0] d);
        logic [CHAR_W-1:0] first;
        logic [CHAR_W-1:0] g;
        int                span;
        span = 3;
        case (d)
            4'd0: return $urandom_range(0, 1) ? "0" : "+";
            4'd1: return "1";
            4'd2: first = "a";
            4'd3: first = "d";
            4'd4: first = "g";
            4'd5: first = "j";
            4'd6: first = "m";
            4'd7:
            begin
                first = "p";
                span  = 4;
            end
            4'd8: first = "t";
            4'd9:
            begin
                first = "w";
                span  = 4;
            end
            default: return CHAR_W'($urandom_range(0, 255));
        endcase
        if ($urandom_range(0, 2) == 0)
            return "0" + d;
        g = first + CHAR_W'($urandom_range(0, span - 1));
        if ($urandom_range(0, 1))
            g = g & ~8'h20;
        return g;
    endfunction

    // Filler: raw bytes, common keypad characters, or pieces of the pattern
    function automatic logic [CHAR_W-1:0] filler_char();
        case ($urandom_range(0, 9))
            0, 1, 2, 3: return CHAR_W'($urandom_range(0, 255));
            4, 5, 6:    return keypad_glyph(DIGIT_W'($urandom_range(0, 9)));
            default:    return keypad_glyph(pat_digits[DIGIT_W*$urandom_range(0, 15) +: DIGIT_W]);
        endcase
    endfunction

    // One field, optionally holding the pattern or a run cut one short
    task automatic send_field(bit with_pattern, logic last);
        int used;
        int cut;
        used = (pat_len > PATTERN_SLOTS) ? PATTERN_SLOTS : pat_len;
        cut  = (with_pattern && used > 0 && $urandom_range(0, 3) == 0) ? 1 : 0;
        repeat ($urandom_range(0, 4)) send_item(filler_char(), 1'b0, 1'($urandom_range(0, 1)));
        if (with_pattern)
            for (int k = 0; k < used - cut; k++)
                send_item(keypad_glyph(pat_digits[DIGIT_W*k +: DIGIT_W]), 1'b0,
                          1'($urandom_range(0, 1)));
        repeat ($urandom_range(0, 4)) send_item(filler_char(), 1'b0, 1'($urandom_range(0, 1)));
        send_item(CHAR_W'($urandom_range(0, 255)), 1'b1, last);
    endtask

    task automatic send_record();
        if ($urandom_range(0, 9) == 0)
        begin
            // Noise: arbitrary items, terminators included
            repeat ($urandom_range(1, 6))
                send_item(CHAR_W'($urandom_range(0, 255)), $urandom_range(0, 3) == 0,
                          1'($urandom_range(0, 1)));
        end
        else
        begin
            send_field($urandom_range(0, 2) == 0, 1'b0);
            send_field($urandom_range(0, 2) == 0, 1'b1);
        end
    endtask

    // Reset state: length 0 never matches; ends_record on a character is ignored
    task automatic test_reset_state;
        send_item("2", 1'b0, 1'b1);
        send_item(8'h00, 1'b1, 1'b0);
        send_item(8'hFF, 1'b1, 1'b1);
    endtask

    // Keypad classes 1, 0 ('+'), 9, 7 and 2: digit, '+', upper and lower case letters
    task automatic test_keypad_classes;
        set_pattern(64'h27901, 5'd5);
        send_item("1", 1'b0, 1'b0);
        send_item("+", 1'b0, 1'b0);
        send_item("Z", 1'b0, 1'b0);
        send_item("s", 1'b0, 1'b0);
        send_item("A", 1'b0, 1'b0);
        send_item(8'h00, 1'b1, 1'b0);
        send_item(8'h00, 1'b1, 1'b1);
    endtask

    // No match across the field boundary; NUL and 0xFF break a run
    task automatic test_run_breaks;
        set_pattern(64'h21, 5'd2);
        send_item("1", 1'b0, 1'b0);
        send_item(8'hFF, 1'b1, 1'b0);
        send_item("2", 1'b0, 1'b0);
        send_item("1", 1'b0, 1'b0);
        send_item(8'h00, 1'b0, 1'b0);
        send_item("2", 1'b0, 1'b0);
        send_item(8'hFF, 1'b0, 1'b1);
        send_item(8'h00, 1'b1, 1'b1);
    endtask

    // Length above the pattern slots, and a digit nibble above 9
    task automatic test_unmatchable_patterns;
        set_pattern(64'h2, 5'd20);
        send_item("a", 1'b0, 1'b0);
        send_item(8'h00, 1'b1, 1'b0);
        send_item(8'h00, 1'b1, 1'b1);
        set_pattern(64'hA, 5'd1);
        send_item(":", 1'b0, 1'b0);
        send_item(8'h00, 1'b1, 1'b0);
        send_item(8'h00, 1'b1, 1'b1);
    endtask

    // Pattern change inside a field keeps the partial run
    task automatic test_midfield_config;
        set_pattern(64'h43, 5'd2);
        send_item("3", 1'b0, 1'b0);
        set_pattern(64'h53, 5'd2);
        send_item("5", 1'b0, 1'b0);
        send_item(8'h00, 1'b1, 1'b0);
        send_item(8'h00, 1'b1, 1'b1);
    endtask

    // Long receiver hold-off fills the block; then a full pause of the sender
    task automatic test_backpressure;
        set_pattern(64'h5, 5'd1);
        gaps_on = 1'b0;
        holdoff_request = 1'b1;
        for (int r = 0; r < 40; r++)
        begin
            send_item((r % 2) ? "x" : "k", 1'b0, 1'b0);
            send_item(8'h00, 1'b1, 1'b0);
            send_item(8'h00, 1'b1, 1'b1);
        end
        drain_results();
        gaps_on = 1'b1;
        repeat (10) send_record();
    endtask

    // Random records over a range of pattern settings
    task automatic test_random_records;
        logic [DIGITS_W-1:0]   digits;
        logic [CFG_DATA_W-1:0] len_word;
        logic [LENGTH_W-1:0]   len;
        int                    start;
        for (int phase = 0; phase < RANDOM_PHASES; phase++)
        begin
            digits = '0;
            for (int k = 0; k < PATTERN_SLOTS; k++)
                digits[DIGIT_W*k +: DIGIT_W] = DIGIT_W'($urandom_range(0, 9));
            case (phase)
                0:       len = 5'd16;
                1:       len = 5'd1;
                2:       len = 5'd0;
                3:       len = LENGTH_W'($urandom_range(17, 30));
                4:       len = 5'd31;
                5:       len = 5'd16;
                default: len = LENGTH_W'($urandom_range(2, 8));
            endcase
            if (phase == 6)
                digits = '0;
            else if (phase == 7)
                digits = '1;
            else if (phase == 3 || phase == 8)
                for (int k = 0; k < PATTERN_SLOTS; k++)
                    if ($urandom_range(0, 5) == 0)
                        digits[DIGIT_W*k +: DIGIT_W] = DIGIT_W'($urandom_range(10, 15));
            // Upper bits of the length word carry junk
            len_word = {$urandom, $urandom};
            len_word[LENGTH_W-1:0] = len;
            wait_block_idle();
            write_reg(kdsm_pkg::REG_PATTERN_DIGITS, digits);
            write_reg(kdsm_pkg::REG_PATTERN_LENGTH, len_word);
            gaps_on = (phase % 3 != 2);
            start = items_sent;
            while (items_sent - start < RANDOM_ITEMS / RANDOM_PHASES)
                send_record();
        end
        gaps_on = 1'b1;
    endtask

    // Receiver hold-off, counted here
    initial
    begin
        forever
        begin
            @(negedge clk);
            if (holdoff_request)
            begin
                holdoff_request = 1'b0;
                hold_active <= 1'b1;
                repeat (HOLDOFF_CYCLES) @(negedge clk);
                hold_active <= 1'b0;
            end
        end
    end

    // Receiver ready pattern
    initial
    begin
        rx_pattern_t pattern;
        int          left;
        pattern = RX_STEADY;
        left    = 0;
        forever
        begin
            @(negedge clk);
            if (left == 0)
            begin
                case ($urandom_range(0, 3))
                    0:       pattern = RX_STEADY;
                    1:       pattern = RX_COIN;
                    2:       pattern = RX_SPARSE;
                    default: pattern = RX_MOSTLY;
                endcase
                left = $urandom_range(20, 120);
            end
            left--;
            if (hold_active)
                result_bus.ready <= 1'b0;
            else
                case (pattern)
                    RX_STEADY: result_bus.ready <= 1'b1;
                    RX_COIN:   result_bus.ready <= 1'($urandom_range(0, 1));
                    RX_SPARSE: result_bus.ready <= (left % 4 == 0);
                    default:   result_bus.ready <= ($urandom_range(0, 9) < 8);
                endcase
        end
    end

    // Result check against the oldest pending verdict
    initial
    begin
        record_verdict_t want;
        forever
        begin
            @(posedge clk);
            if (rst_n && result_bus.valid && result_bus.ready)
            begin
                if (record_verdicts_due.size() == 0)
                begin
                    mismatches++;
                    if (mismatches <= REPORT_LIMIT)
                        $display("Unexpected result: matched %0b total %0d",
                                 result_bus.record_matched, result_bus.matched_total);
                end
                else
                begin
                    want = record_verdicts_due.pop_front();
                    records_checked++;
                    if (want.matched)
                        records_matched++;
                    if (result_bus.record_matched !== want.matched)
                    begin
                        mismatches++;
                        if (mismatches <= REPORT_LIMIT)
                            $display("Record %0d: record_matched expected %0b, got %0b",
                                     records_checked, want.matched,
                                     result_bus.record_matched);
                    end
                    if (result_bus.matched_total !== want.total)
                    begin
                        mismatches++;
                        if (mismatches <= REPORT_LIMIT)
                            $display("Record %0d: matched_total expected %0d, got %0d",
                                     records_checked, want.total,
                                     result_bus.matched_total);
                    end
                end
            end
        end
    end

    // Test sequence
    initial
    begin
        rst_n                  = 1'b0;
        cfg_bus.valid          = 1'b0;
        cfg_bus.index          = kdsm_pkg::REG_PATTERN_DIGITS;
        cfg_bus.data           = '0;
        char_bus.valid         = 1'b0;
        char_bus.char_code     = '0;
        char_bus.is_terminator = 1'b0;
        char_bus.ends_record   = 1'b0;
        result_bus.ready       = 1'b0;
        pat_digits             = '0;
        pat_len                = '0;
        run_bits               = '0;
        found_in_record        = 1'b0;
        match_tally            = '0;
        items_sent             = 0;
        burst_left             = 0;
        gaps_on                = 1'b1;
        holdoff_request        = 1'b0;
        mismatches             = 0;
        records_checked        = 0;
        records_matched        = 0;

        repeat (8) @(posedge clk);
        @(negedge clk);
        rst_n <= 1'b1;

        test_reset_state();
        test_keypad_classes();
        test_run_breaks();
        test_unmatchable_patterns();
        test_midfield_config();
        test_backpressure();
        test_random_records();

        drain_results();
        repeat (SETTLE_CYCLES * 2) @(posedge clk);

        $display("Checked %0d record results (%0d matched) from %0d items", records_checked,
                 records_matched, items_sent);
        $display("Covered keypad classes, lengths 0 to 31, nibbles above 9, stalls; tally %0d",
                 match_tally);
        if (mismatches == 0 && record_verdicts_due.size() == 0)
            $display("All tests passed");
        else
            $display("Some tests failed");
        $finish;
    end

endmodule

### files.f
rtl/core/kdsm_pkg.sv
rtl/core/kdsm_if.sv
rtl/core/kdsm_match_unit.sv
rtl/core/keypad_digit_substring_matcher.sv
dv/keypad_digit_substring_matcher_test.sv
